// ----- rtl/ppl_pkg.sv -----
// ----------------------------------------------------------------------------
// ppl_pkg
// Shared types and constants for the packet payload locator.
// ----------------------------------------------------------------------------
package ppl_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 2048;

    typedef enum logic [2:0] {
        ST_ETH,
        ST_IP4,
        ST_IP6,
        ST_FRAG,
        ST_TCP,
        ST_FIX8,
        ST_PAYLOAD,
        ST_DONE
    } stage_t;

    localparam logic [2:0] V_PAYLOAD   = 3'd0;
    localparam logic [2:0] V_EMPTY     = 3'd1;
    localparam logic [2:0] V_OTHER_L3  = 3'd2;
    localparam logic [2:0] V_GRE       = 3'd3;
    localparam logic [2:0] V_PIM       = 3'd4;
    localparam logic [2:0] V_OTHER_L4  = 3'd5;
    localparam logic [2:0] V_NESTED    = 3'd6;
    localparam logic [2:0] V_TRUNCATED = 3'd7;

    localparam logic [1:0] L3_IP4 = 2'd1;
    localparam logic [1:0] L3_IP6 = 2'd2;

    localparam logic [2:0] L4_TCP    = 3'd1;
    localparam logic [2:0] L4_UDP    = 3'd2;
    localparam logic [2:0] L4_ESP    = 3'd3;
    localparam logic [2:0] L4_ICMP   = 3'd4;
    localparam logic [2:0] L4_ICMPV6 = 3'd5;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_IPIP   = 8'd4;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_IP6    = 8'd41;
    localparam logic [7:0] PROTO_FRAG   = 8'd44;
    localparam logic [7:0] PROTO_GRE    = 8'd47;
    localparam logic [7:0] PROTO_ESP    = 8'd50;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0] PROTO_PIM    = 8'd103;

    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IP4  = 16'h0800;
    localparam logic [15:0] ETYPE_IP6  = 16'h86DD;

    // One classified beat on its way to the output.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        in_payload;
        logic        frame_done;
        logic [2:0]  verdict;
        logic [11:0] payload_offset;
        logic [11:0] payload_length;
        logic        vlan_seen;
        logic [1:0]  l3_kind;
        logic [2:0]  l4_kind;
        logic        ipip_seen;
        logic        ip6_in_ip4_seen;
        logic        fragment_seen;
    } rec_t;

endpackage

// ----- rtl/packet_payload_locator_unit.sv -----
// ----------------------------------------------------------------------------
// packet_payload_locator_unit
// Finds the payload of an Ethernet frame and marks every byte.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tdata: data_byte; tlast: last_byte
// m_axis    out        tdata: byte and frame summary; tuser: in_payload;
//                      tlast: frame_done
// One beat per cycle is accepted and delivered when neither side stalls.
// The header walker decides each beat in the cycle it is accepted and a
// two-entry queue holds the results, so the input runs on while the output
// stalls until the queue is full. Reset returns the walker to the start of
// a frame and empties the queue.
module packet_payload_locator_unit #(
    parameter int MAX_FRAME_BYTES = ppl_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [10:8] verdict, [22:11] payload_offset,
    // [34:23] payload_length, [35] vlan_seen, [37:36] l3_kind,
    // [40:38] l4_kind, [41] ipip_seen, [42] ip6_in_ip4_seen,
    // [43] fragment_seen, [47:44] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] in_payload
    output logic        m_axis_tlast
);
    import ppl_pkg::*;

    rec_t front_rec;
    rec_t out_rec;
    logic full;
    logic accept;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    ppl_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .data_byte(s_axis_tdata),
        .last_byte(s_axis_tlast),
        .rec(front_rec)
    );

    ppl_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(accept),
        .push_rec(front_rec),
        .full(full),
        .out_valid(m_axis_tvalid),
        .pop(m_axis_tvalid && m_axis_tready),
        .out_rec(out_rec)
    );

    assign m_axis_tdata = {4'b0000, out_rec.fragment_seen, out_rec.ip6_in_ip4_seen,
                           out_rec.ipip_seen, out_rec.l4_kind, out_rec.l3_kind,
                           out_rec.vlan_seen, out_rec.payload_length,
                           out_rec.payload_offset, out_rec.verdict, out_rec.out_byte};
    assign m_axis_tuser = out_rec.in_payload;
    assign m_axis_tlast = out_rec.frame_done;

endmodule

// ----- rtl/ppl_front.sv -----
// ----------------------------------------------------------------------------
// ppl_front
// Header walker: tracks the parse stage and classifies each accepted beat.
// ----------------------------------------------------------------------------
module ppl_front #(
    parameter int MAX_FRAME_BYTES = ppl_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output ppl_pkg::rec_t rec
);
    import ppl_pkg::*;

    localparam int IW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 64);
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_FRAME_BYTES);

    stage_t        stage_reg, stage_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [PW-1:0] hs_reg, hs_next;
    logic [PW-1:0] nhe_reg, nhe_next;
    logic [15:0]   tf_reg, tf_next;
    logic [7:0]    np_reg, np_next;
    logic          tun_reg, tun_next;
    logic          vlan_reg, vlan_next;
    logic [1:0]    l3_reg, l3_next;
    logic [2:0]    l4_reg, l4_next;
    logic          ipip_reg, ipip_next;
    logic          ip6_reg, ip6_next;
    logic          frag_reg, frag_next;
    logic [2:0]    fv_reg, fv_next;

    logic [PW-1:0] pos, nxt, rel;
    logic          at_end;
    logic [15:0]   tf_upd;
    logic [7:0]    np_upd;
    logic [5:0]    tcp_len;
    logic [2:0]    verdict;
    logic [PW-1:0] len;

    assign pos     = PW'(idx_reg);
    assign nxt     = pos + PW'(1);
    assign rel     = pos - hs_reg;
    assign at_end  = (nxt == nhe_reg);
    assign tcp_len = (data_byte[7:4] < 4'd5) ? 6'd20 : {data_byte[7:4], 2'b00};

    always_comb
    begin
        stage_next = stage_reg;
        idx_next   = idx_reg;
        hs_next    = hs_reg;
        nhe_next   = nhe_reg;
        tf_next    = tf_reg;
        np_next    = np_reg;
        tun_next   = tun_reg;
        vlan_next  = vlan_reg;
        l3_next    = l3_reg;
        l4_next    = l4_reg;
        ipip_next  = ipip_reg;
        ip6_next   = ip6_reg;
        frag_next  = frag_reg;
        fv_next    = fv_reg;
        tf_upd     = tf_reg;
        np_upd     = np_reg;
        if (idx_reg < MAX_IDX)
        begin
            idx_next = idx_reg + IW'(1);
            unique case (stage_reg)
                ST_ETH:
                begin
                    if ((pos + PW'(2) == nhe_reg) || at_end)
                        tf_upd = {tf_reg[7:0], data_byte};
                    tf_next = tf_upd;
                    if (at_end)
                    begin
                        if (tf_upd == ETYPE_VLAN && nhe_reg == PW'(14))
                        begin
                            vlan_next = 1'b1;
                            nhe_next  = PW'(18);
                            tf_next   = '0;
                        end
                        else if (tf_upd == ETYPE_IP4)
                        begin
                            l3_next    = L3_IP4;
                            stage_next = ST_IP4;
                            hs_next    = nxt;
                            nhe_next   = nxt + PW'(20);
                        end
                        else if (tf_upd == ETYPE_IP6)
                        begin
                            l3_next    = L3_IP6;
                            stage_next = ST_IP6;
                            hs_next    = nxt;
                            nhe_next   = nxt + PW'(40);
                        end
                        else
                        begin
                            fv_next    = V_OTHER_L3;
                            stage_next = ST_DONE;
                        end
                    end
                end
                ST_IP4, ST_IP6, ST_FRAG:
                begin
                    if ((stage_reg == ST_IP4 && rel == PW'(9))
                        || (stage_reg == ST_IP6 && rel == PW'(6))
                        || (stage_reg == ST_FRAG && rel == PW'(0)))
                        np_upd = data_byte;
                    np_next = np_upd;
                    if (at_end)
                    begin
                        hs_next = nxt;
                        unique case (np_upd)
                            PROTO_TCP:
                            begin
                                l4_next = L4_TCP; stage_next = ST_TCP;
                                nhe_next = nxt + PW'(20);
                            end
                            PROTO_UDP:
                            begin
                                l4_next = L4_UDP; stage_next = ST_FIX8;
                                nhe_next = nxt + PW'(8);
                            end
                            PROTO_ESP:
                            begin
                                l4_next = L4_ESP; stage_next = ST_FIX8;
                                nhe_next = nxt + PW'(8);
                            end
                            PROTO_ICMP:
                            begin
                                l4_next = L4_ICMP; stage_next = ST_FIX8;
                                nhe_next = nxt + PW'(8);
                            end
                            PROTO_ICMPV6:
                            begin
                                l4_next = L4_ICMPV6; stage_next = ST_FIX8;
                                nhe_next = nxt + PW'(8);
                            end
                            PROTO_IPIP:
                            begin
                                if (tun_reg)
                                begin
                                    fv_next = V_NESTED; stage_next = ST_DONE;
                                    hs_next = hs_reg;
                                end
                                else
                                begin
                                    tun_next = 1'b1; ipip_next = 1'b1;
                                    stage_next = ST_IP4;
                                    nhe_next = nxt + PW'(20);
                                end
                            end
                            PROTO_FRAG:
                            begin
                                frag_next = 1'b1; stage_next = ST_FRAG;
                                nhe_next = nxt + PW'(8);
                            end
                            PROTO_IP6:
                            begin
                                ip6_next = 1'b1; stage_next = ST_IP6;
                                nhe_next = nxt + PW'(40);
                            end
                            PROTO_GRE:
                            begin
                                fv_next = V_GRE; stage_next = ST_DONE; hs_next = hs_reg;
                            end
                            PROTO_PIM:
                            begin
                                fv_next = V_PIM; stage_next = ST_DONE; hs_next = hs_reg;
                            end
                            default:
                            begin
                                fv_next = V_OTHER_L4; stage_next = ST_DONE;
                                hs_next = hs_reg;
                            end
                        endcase
                    end
                end
                ST_TCP:
                begin
                    if (rel == PW'(12))
                        nhe_next = hs_reg + PW'(tcp_len);
                    else if (at_end)
                    begin
                        stage_next = ST_PAYLOAD;
                        hs_next    = nxt;
                    end
                end
                ST_FIX8:
                begin
                    if (at_end)
                    begin
                        stage_next = ST_PAYLOAD;
                        hs_next    = nxt;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        len = '0;
        if (PW'(idx_next) > hs_next)
            len = PW'(idx_next) - hs_next;
        unique case (stage_next)
            ST_PAYLOAD: verdict = (len != '0) ? V_PAYLOAD : V_EMPTY;
            ST_DONE:    verdict = fv_next;
            default:    verdict = V_TRUNCATED;
        endcase
        rec                = '0;
        rec.out_byte       = data_byte;
        rec.in_payload     = (stage_reg == ST_PAYLOAD);
        if (last_byte)
        begin
            rec.frame_done      = 1'b1;
            rec.verdict         = verdict;
            if (stage_next == ST_PAYLOAD)
            begin
                rec.payload_offset = 12'(hs_next);
                rec.payload_length = 12'(len);
            end
            rec.vlan_seen       = vlan_next;
            rec.l3_kind         = l3_next;
            rec.l4_kind         = l4_next;
            rec.ipip_seen       = ipip_next;
            rec.ip6_in_ip4_seen = ip6_next;
            rec.fragment_seen   = frag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_ETH;
            idx_reg   <= '0;
            hs_reg    <= '0;
            nhe_reg   <= PW'(14);
            tf_reg    <= '0;
            np_reg    <= '0;
            tun_reg   <= 1'b0;
            vlan_reg  <= 1'b0;
            l3_reg    <= '0;
            l4_reg    <= '0;
            ipip_reg  <= 1'b0;
            ip6_reg   <= 1'b0;
            frag_reg  <= 1'b0;
            fv_reg    <= '0;
        end
        else if (accept && last_byte)
        begin
            stage_reg <= ST_ETH;
            idx_reg   <= '0;
            hs_reg    <= '0;
            nhe_reg   <= PW'(14);
            tf_reg    <= '0;
            np_reg    <= '0;
            tun_reg   <= 1'b0;
            vlan_reg  <= 1'b0;
            l3_reg    <= '0;
            l4_reg    <= '0;
            ipip_reg  <= 1'b0;
            ip6_reg   <= 1'b0;
            frag_reg  <= 1'b0;
            fv_reg    <= '0;
        end
        else if (accept)
        begin
            stage_reg <= stage_next;
            idx_reg   <= idx_next;
            hs_reg    <= hs_next;
            nhe_reg   <= nhe_next;
            tf_reg    <= tf_next;
            np_reg    <= np_next;
            tun_reg   <= tun_next;
            vlan_reg  <= vlan_next;
            l3_reg    <= l3_next;
            l4_reg    <= l4_next;
            ipip_reg  <= ipip_next;
            ip6_reg   <= ip6_next;
            frag_reg  <= frag_next;
            fv_reg    <= fv_next;
        end
    end

endmodule

// ----- rtl/ppl_queue.sv -----
// ----------------------------------------------------------------------------
// ppl_queue
// Two-entry queue that holds classified beats and drives the output side.
// ----------------------------------------------------------------------------
module ppl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ppl_pkg::rec_t push_rec,
    output logic          full,
    output logic          out_valid,
    input  logic          pop,
    output ppl_pkg::rec_t out_rec
);
    import ppl_pkg::*;

    rec_t       mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_rec   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/ppl_checker.sv -----
// ----------------------------------------------------------------------------
// ppl_checker
// Port-level checks on the locator output, bound to the top level.
// ----------------------------------------------------------------------------
module ppl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Summary fields are zero on every beat but the last of a frame.
    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[43:8] == 36'd0)
        else $error("summary fields set on a beat that does not end a frame");

    // A verdict other than payload or empty means offset and length are zero.
    a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[10:9] != 2'b00
        |-> m_axis_tdata[34:11] == 24'd0)
        else $error("offset or length reported without a payload");

    // A payload verdict always comes with a non-zero length or offset.
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[10:8] == 3'd0
        |-> m_axis_tdata[34:23] != 12'd0 || m_axis_tdata[22:11] != 12'd0)
        else $error("payload verdict with empty position");

    // A stalled beat is held.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

endmodule

bind packet_payload_locator_unit ppl_checker u_ppl_checker (
    .clk(clk),
    .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
